/* hdl/bsfe_pkg.sv */
`default_nettype none

package bsfe_pkg;

   // Frame bytes and escape codes
   localparam logic [7:0] HEAD_BYTE    = 8'hF4;
   localparam logic [7:0] TAIL_BYTE    = 8'h4F;
   localparam logic [7:0] ESC_BYTE     = 8'hFF;
   localparam logic [7:0] HEAD_CODE    = 8'h01;
   localparam logic [7:0] ESC_CODE     = 8'h02;
   localparam logic [7:0] TAIL_CODE    = 8'h03;
   localparam logic [7:0] LEN_OVERHEAD = 8'd6;
   localparam logic [7:0] PROP_RESET   = 8'h01;
   localparam logic [7:0] MAX_PAYLOAD  = 8'd249;

   // CRC-16/CCITT-FALSE
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;

   // Symbol queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   // One raw frame byte on its way to the line
   typedef struct packed {
      logic [7:0] data;
      logic       stuff;        // subject to escaping
      logic       frame_end;
      logic       length_error;
      logic       last;
   } sym_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/bsfe_front.sv */
`default_nettype none

module bsfe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_payload_byte,
   input  wire logic [7:0]        req_frame_length,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data,
   input  wire logic              q_full,
   output logic                   q_push,
   output bsfe_pkg::sym_type      q_sym
);

   typedef enum logic [2:0] {
      S_ITEM, S_LEN, S_PROP, S_DATA, S_CRCH, S_CRCL, S_TAIL
   } state_type;

   state_type   state_ff, state_in;
   logic        in_frame_ff, in_frame_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  payload_ff, payload_in;
   logic [7:0]  lenb_ff, lenb_in;
   logic [7:0]  prop_ff, prop_in;
   logic        accept;
   logic        bad_len;
   logic        final_byte;

   assign req_stall  = (state_ff != S_ITEM) || q_full;
   assign accept     = req_valid && !req_stall;
   assign bad_len    = (req_frame_length == 8'd0) || (req_frame_length > bsfe_pkg::MAX_PAYLOAD);
   assign final_byte = (bytes_left_ff == 8'd1);

   always_comb begin
      state_in      = state_ff;
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      crc_in        = crc_ff;
      payload_in    = payload_ff;
      lenb_in       = lenb_ff;
      prop_in       = csr_wr_en ? csr_wr_data : prop_ff;
      q_push        = 1'b0;
      q_sym         = '{data: 8'h00, stuff: 1'b0, frame_end: 1'b0,
                        length_error: 1'b0, last: 1'b0};

      unique case (state_ff)
         S_ITEM: begin
            if (accept) begin
               q_push = 1'b1;
               if (!in_frame_ff) begin
                  if (bad_len) begin
                     q_sym.length_error = 1'b1;
                     q_sym.last         = 1'b1;
                  end else begin
                     q_sym.data    = bsfe_pkg::HEAD_BYTE;
                     lenb_in       = req_frame_length + bsfe_pkg::LEN_OVERHEAD;
                     payload_in    = req_payload_byte;
                     bytes_left_in = req_frame_length;
                     crc_in        = bsfe_pkg::crc_byte(bsfe_pkg::CRC_SEED, lenb_in);
                     in_frame_in   = 1'b1;
                     state_in      = S_LEN;
                  end
               end else begin
                  q_sym.data    = req_payload_byte;
                  q_sym.stuff   = 1'b1;
                  q_sym.last    = !final_byte;
                  crc_in        = bsfe_pkg::crc_byte(crc_ff, req_payload_byte);
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (final_byte) begin
                     state_in = S_CRCH;
                  end
               end
            end
         end
         S_LEN: begin
            if (!q_full) begin
               q_push      = 1'b1;
               q_sym.data  = lenb_ff;
               q_sym.stuff = 1'b1;
               state_in    = S_PROP;
            end
         end
         S_PROP: begin
            if (!q_full) begin
               q_push      = 1'b1;
               q_sym.data  = prop_ff;
               q_sym.stuff = 1'b1;
               crc_in      = bsfe_pkg::crc_byte(crc_ff, prop_ff);
               state_in    = S_DATA;
            end
         end
         S_DATA: begin
            if (!q_full) begin
               q_push        = 1'b1;
               q_sym.data    = payload_ff;
               q_sym.stuff   = 1'b1;
               q_sym.last    = !final_byte;
               crc_in        = bsfe_pkg::crc_byte(crc_ff, payload_ff);
               bytes_left_in = bytes_left_ff - 8'd1;
               state_in      = final_byte ? S_CRCH : S_ITEM;
            end
         end
         S_CRCH: begin
            if (!q_full) begin
               q_push      = 1'b1;
               q_sym.data  = crc_ff[15:8];
               q_sym.stuff = 1'b1;
               state_in    = S_CRCL;
            end
         end
         S_CRCL: begin
            if (!q_full) begin
               q_push      = 1'b1;
               q_sym.data  = crc_ff[7:0];
               q_sym.stuff = 1'b1;
               state_in    = S_TAIL;
            end
         end
         S_TAIL: begin
            if (!q_full) begin
               q_push          = 1'b1;
               q_sym.data      = bsfe_pkg::TAIL_BYTE;
               q_sym.frame_end = 1'b1;
               q_sym.last      = 1'b1;
               crc_in          = bsfe_pkg::CRC_SEED;
               in_frame_in     = 1'b0;
               state_in        = S_ITEM;
            end
         end
         default: begin
            state_in = S_ITEM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_ITEM;
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= 8'd0;
         crc_ff        <= bsfe_pkg::CRC_SEED;
         prop_ff       <= bsfe_pkg::PROP_RESET;
      end else begin
         state_ff      <= state_in;
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
         prop_ff       <= prop_in;
      end
      payload_ff <= payload_in;
      lenb_ff    <= lenb_in;
   end

endmodule

`default_nettype wire

/* hdl/bsfe_queue.sv */
`default_nettype none

module bsfe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bsfe_pkg::sym_type  push_sym,
   output logic                    full,
   input  wire logic               pop,
   output bsfe_pkg::sym_type       pop_sym,
   output logic                    empty
);

   bsfe_pkg::sym_type            entry_ff [bsfe_pkg::Q_DEPTH];
   logic [bsfe_pkg::Q_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bsfe_pkg::Q_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bsfe_pkg::Q_CW-1:0]    count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign full    = (count_ff == bsfe_pkg::Q_CW'(bsfe_pkg::Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_sym = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? bsfe_pkg::Q_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bsfe_pkg::Q_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_sym;
      end
   end

endmodule

`default_nettype wire

/* hdl/bsfe_back.sv */
`default_nettype none

module bsfe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire bsfe_pkg::sym_type  q_sym,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_frame_end,
   output logic                    rsp_length_error,
   output logic                    rsp_last
);

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        err_ff, err_in;
   logic        last_ff, last_in;
   logic        pend_ff, pend_in;       // escape code still owed
   logic [7:0]  pend_code_ff, pend_code_in;
   logic        pend_last_ff, pend_last_in;
   logic        load;
   logic        needs_esc;
   logic [7:0]  esc_code;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      unique case (q_sym.data)
         bsfe_pkg::HEAD_BYTE: esc_code = bsfe_pkg::HEAD_CODE;
         bsfe_pkg::ESC_BYTE:  esc_code = bsfe_pkg::ESC_CODE;
         bsfe_pkg::TAIL_BYTE: esc_code = bsfe_pkg::TAIL_CODE;
         default:             esc_code = 8'h00;
      endcase
      needs_esc = q_sym.stuff && ((q_sym.data == bsfe_pkg::HEAD_BYTE) ||
                                  (q_sym.data == bsfe_pkg::ESC_BYTE) ||
                                  (q_sym.data == bsfe_pkg::TAIL_BYTE));
   end

   always_comb begin
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      pend_code_in = pend_code_ff;
      pend_last_in = pend_last_ff;
      q_pop        = 1'b0;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            byte_in  = pend_code_ff;
            end_in   = 1'b0;
            err_in   = 1'b0;
            last_in  = pend_last_ff;
            pend_in  = 1'b0;
         end else if (!q_empty) begin
            q_pop    = 1'b1;
            valid_in = 1'b1;
            end_in   = q_sym.frame_end;
            err_in   = q_sym.length_error;
            if (needs_esc) begin
               byte_in      = bsfe_pkg::ESC_BYTE;
               last_in      = 1'b0;
               pend_in      = 1'b1;
               pend_code_in = esc_code;
               pend_last_in = q_sym.last;
            end else begin
               byte_in = q_sym.data;
               last_in = q_sym.last;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      byte_ff      <= byte_in;
      end_ff       <= end_in;
      err_ff       <= err_in;
      last_ff      <= last_in;
      pend_code_ff <= pend_code_in;
      pend_last_ff <= pend_last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_frame_end    = end_ff;
   assign rsp_length_error = err_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

/* hdl/byte_stuffed_frame_encoder.sv */
`default_nettype none

// Channel  Dir  Handshake              Payload
// req      in   req_valid/req_stall    req_payload_byte[7:0], req_frame_length[7:0]
// rsp      out  rsp_valid/rsp_stall    rsp_out_byte[7:0], rsp_frame_end, rsp_length_error,
//                                      rsp_last
// csr      in   csr_wr_en              csr_wr_data[7:0] (frame property byte)
//
// One line byte per cycle unless rsp_stall; an escaped payload byte becomes two line bytes.
// A frame's first transaction also yields head, length and property, its last the CRC pair
// and tail. Output bandwidth sets the sustained rate.
// Reset is synchronous, active high: idle, CRC preset to all ones, property byte 0x01.
// req_stall is high while the front queues length, property, first data byte, CRC, tail
// and while the 4-entry queue is full: the only way rsp_stall reaches the request side.

module byte_stuffed_frame_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_payload_byte,
   input  wire logic [7:0]  req_frame_length,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic             rsp_length_error,
   output logic             rsp_last,
   // config
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   // Front: takes a transaction, decides frame start / body / bad length, runs the
   // CRC one byte per cycle unless q_full and expands the frame into raw, unescaped symbols.
   bsfe_pkg::sym_type push_sym;
   bsfe_pkg::sym_type pop_sym;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;

   bsfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_frame_length (req_frame_length),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_full           (q_full),
      .q_push           (push),
      .q_sym            (push_sym)
   );

   // Short symbol queue decouples the CRC/expansion side from line stalls.
   bsfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_sym (push_sym),
      .full     (q_full),
      .pop      (pop),
      .pop_sym  (pop_sym),
      .empty    (q_empty)
   );

   // Back: escapes stuffed 0xF4/0xFF/0x4F into 0xFF + code and drives the output register.
   // The last flag of an escaped symbol moves to its second byte.
   bsfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_sym            (pop_sym),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_length_error (rsp_length_error),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
